// ===== src/alct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alct_pkg - shared types and codes for the array list cursor table
// command and status codes, input and result word layouts
// ----------------------------------------------------------------------------
package alct_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCOUNT_W = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] in_value;
  } alct_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       result_status;
    logic signed [VALUE_W-1:0] item_value;
    logic [OCOUNT_W-1:0]       item_count;
  } alct_out_t;

endpackage

// ===== src/alct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alct_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module alct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ===== src/array_list_cursor_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_cursor_table_core - packed list with an iteration cursor
// entries live in one ram; remove shifts later entries down one per cycle
// results: insert, clear and refused commands give their result in the cycle after
//   start; first and next read the ram, then register the item in the result word
// remove reads the cursor entry, then moves each later entry down (ram shift loop)
// next word is accepted at the edge that takes the result; results cannot stall
// reset empties the list and drops the cursor; ram contents are not cleared
// ----------------------------------------------------------------------------
module array_list_cursor_table_core
  import alct_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  alct_in_t  in_word,
  output logic      out_valid,
  output alct_out_t out_word
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RM_READ,
    S_SHIFT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]         cur_r, cur_nxt;
  logic                      cur_valid_r, cur_valid_nxt;
  logic [ADDR_W-1:0]         wr_idx_r, wr_idx_nxt;
  logic signed [VALUE_W-1:0] rm_item_r, rm_item_nxt;
  logic                      out_valid_r, out_valid_nxt;
  alct_out_t                 out_r, out_nxt;

  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_wa, ram_ra;
  logic [VALUE_W-1:0]        ram_wd, ram_rd;

  logic [CMP_W-1:0]          cnt_ext, cur_ext, wr_ext;
  logic                      full, cur_ok;
  logic [CNT_W+OCOUNT_W-1:0] cnt_wide;

  alct_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign cnt_ext = CMP_W'(cnt_r);
  assign cur_ext = CMP_W'(cur_r);
  assign wr_ext  = CMP_W'(wr_idx_r);
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign cur_ok  = cur_valid_r && (cur_ext < cnt_ext);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    wr_idx_nxt    = wr_idx_r;
    rm_item_nxt   = rm_item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_wa        = wr_idx_r;
    ram_wd        = ram_rd;
    ram_re        = 1'b0;
    ram_ra        = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt.result_status = ST_DONE;
          out_nxt.item_value    = '0;
          case (in_word.cmd)
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.result_status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                ram_wa  = cnt_r[ADDR_W-1:0];
                ram_wd  = in_word.in_value;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CMD_FIRST: begin
              if (cnt_r == '0) begin
                out_valid_nxt         = 1'b1;
                out_nxt.result_status = ST_END;
              end else begin
                ram_re        = 1'b1;
                ram_ra        = '0;
                cur_nxt       = '0;
                cur_valid_nxt = 1'b1;
                state_nxt     = S_READ;
              end
            end
            CMD_NEXT: begin
              if (!cur_valid_r && (cnt_r != '0)) begin
                ram_re        = 1'b1;
                ram_ra        = '0;
                cur_nxt       = '0;
                cur_valid_nxt = 1'b1;
                state_nxt     = S_READ;
              end else if (cur_valid_r && (cur_ext + CMP_W'(1) < cnt_ext)) begin
                ram_re    = 1'b1;
                ram_ra    = cur_r + ADDR_W'(1);
                cur_nxt   = cur_r + ADDR_W'(1);
                state_nxt = S_READ;
              end else begin
                out_valid_nxt         = 1'b1;
                out_nxt.result_status = ST_END;
              end
            end
            CMD_REMOVE: begin
              if (cur_ok) begin
                ram_re    = 1'b1;
                ram_ra    = cur_r;
                state_nxt = S_RM_READ;
              end else begin
                out_valid_nxt         = 1'b1;
                out_nxt.result_status = ST_NOCUR;
              end
            end
            CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              cnt_nxt       = '0;
              cur_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt         = 1'b1;
        out_nxt.result_status = ST_DONE;
        out_nxt.item_value    = ram_rd;
        state_nxt             = S_IDLE;
      end
      S_RM_READ: begin
        rm_item_nxt = ram_rd;
        if (cur_ext + CMP_W'(1) < cnt_ext) begin
          ram_re     = 1'b1;
          ram_ra     = cur_r + ADDR_W'(1);
          wr_idx_nxt = cur_r;
          state_nxt  = S_SHIFT;
        end else begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_status = ST_DONE;
          out_nxt.item_value    = ram_rd;
          cnt_nxt               = cnt_r - CNT_W'(1);
          cur_valid_nxt         = (cur_r != '0);
          cur_nxt               = cur_r - ADDR_W'(1);
          state_nxt             = S_IDLE;
        end
      end
      S_SHIFT: begin
        // move entry wr_idx+1 down to wr_idx, prefetch wr_idx+2
        ram_we     = 1'b1;
        ram_wa     = wr_idx_r;
        ram_wd     = ram_rd;
        wr_idx_nxt = wr_idx_r + ADDR_W'(1);
        if (wr_ext + CMP_W'(2) < cnt_ext) begin
          ram_re = 1'b1;
          ram_ra = wr_idx_r + ADDR_W'(2);
        end else begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_status = ST_DONE;
          out_nxt.item_value    = rm_item_r;
          cnt_nxt               = cnt_r - CNT_W'(1);
          cur_valid_nxt         = (cur_r != '0);
          cur_nxt               = cur_r - ADDR_W'(1);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cnt_wide           = {{OCOUNT_W{1'b0}}, cnt_nxt};
    out_nxt.item_count = cnt_wide[OCOUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    wr_idx_r  <= wr_idx_nxt;
    rm_item_r <= rm_item_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // cursor never points past the stored entries
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_ext < cnt_ext))
    else $error("cursor beyond entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.cmd == CMD_INSERT)) |=> out_valid)
    else $error("insert gave no result word");

  a_shift_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (ram_we && (!ram_re || (ram_ra != ram_wa))))
    else $error("shift step without write or with read-write collision");

  a_busy_no_strobe_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (out_valid && !busy))
    else $error("read step did not finish the command");

endmodule

// ===== dv/array_list_cursor_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_cursor_table_core_tb - self-checking bench for the cursor list
// a scoreboard class predicts each result from the accepted command words;
// directed corner cases come first, then random fill, walk and noise runs
// under three sender idling mixes, with a full drain between phases
// ----------------------------------------------------------------------------
module array_list_cursor_table_core_tb;
  import alct_pkg::*;

  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_CLEAR + 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  class list_scoreboard;
    logic signed [VALUE_W-1:0] entries [CAPACITY];
    int unsigned               total;
    int                        cursor;
    alct_out_t                 expected_q [$];
    int unsigned               errors;

    function new();
      total  = 0;
      cursor = -1;
      errors = 0;
    endfunction

    function void note_command(alct_in_t w);
      alct_out_t res;
      res.result_status = ST_DONE;
      res.item_value    = '0;
      case (w.cmd)
        CMD_INSERT: begin
          if (total >= CAPACITY) begin
            res.result_status = ST_FULL;
          end else begin
            entries[total] = w.in_value;
            total++;
          end
        end
        CMD_FIRST: begin
          if (total == 0) begin
            res.result_status = ST_END;
          end else begin
            cursor         = 0;
            res.item_value = entries[0];
          end
        end
        CMD_NEXT: begin
          if (cursor >= int'(total) - 1) begin
            res.result_status = ST_END;
          end else begin
            cursor++;
            res.item_value = entries[cursor];
          end
        end
        CMD_REMOVE: begin
          if (cursor < 0 || cursor >= int'(total)) begin
            res.result_status = ST_NOCUR;
          end else begin
            res.item_value = entries[cursor];
            for (int i = cursor; i + 1 < int'(total); i++) entries[i] = entries[i + 1];
            total--;
            cursor--;
          end
        end
        CMD_CLEAR: begin
          total  = 0;
          cursor = -1;
        end
        default: ;
      endcase
      res.item_count = total[OCOUNT_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(alct_out_t got);
      alct_out_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: status %0d value %0d count %0d",
               got.result_status, got.item_value, got.item_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result_status !== want.result_status) begin
        $error("result_status expected %0d got %0d", want.result_status, got.result_status);
        errors++;
      end
      if (got.item_value !== want.item_value) begin
        $error("item_value expected %0d got %0d", want.item_value, got.item_value);
        errors++;
      end
      if (got.item_count !== want.item_count) begin
        $error("item_count expected %0d got %0d", want.item_count, got.item_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  alct_in_t    in_word = '0;
  logic        out_valid;
  alct_out_t   out_word;

  list_scoreboard sb = new();
  int unsigned    idle_pct = 0;
  int unsigned    words_sent = 0;
  int unsigned    cycles = 0;

  array_list_cursor_table_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_command(in_word);
    if (rst_n && out_valid) sb.check_result(out_word);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("array_list_cursor_table_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
    alct_in_t w;
    w.cmd      = cmd;
    w.in_value = v;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic fill_run();
    int unsigned n;
    if ($urandom_range(4) == 0) n = CAPACITY - sb.total + $urandom_range(1, 3);
    else n = $urandom_range(1, 12);
    repeat (n) issue(CMD_INSERT, pick_value());
  endtask

  task automatic walk_run();
    int unsigned steps;
    steps = $urandom_range(1, sb.total + 2);
    if ($urandom_range(3) != 0) issue(CMD_FIRST, pick_value());
    repeat (steps) begin
      if ($urandom_range(99) < 30) issue(CMD_REMOVE, pick_value());
      else issue(CMD_NEXT, pick_value());
    end
  endtask

  task automatic noise_run();
    repeat ($urandom_range(1, 4)) issue(3'($urandom_range(CMD_SPARE_HI)), $urandom);
  endtask

  task automatic random_phase(int unsigned pct, int unsigned upto);
    idle_pct = pct;
    while (words_sent < upto) begin
      case ($urandom_range(9))
        0, 1, 2: fill_run();
        3, 4, 5, 6: walk_run();
        7, 8: noise_run();
        default: begin
          if ($urandom_range(2) == 0) issue(CMD_CLEAR, pick_value());
          else issue(CMD_REMOVE, pick_value());
        end
      endcase
    end
  endtask

  initial begin
    int unsigned base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases on an empty list, value extremes, cursor at both ends
    idle_pct = 29;
    issue(CMD_FIRST, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_REMOVE, '0);
    issue(CMD_CLEAR, '0);
    issue(CMD_INSERT, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sh7fff_ffff);
    issue(CMD_INSERT, '0);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_NEXT, '0);
    issue(CMD_FIRST, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_REMOVE, '0);
    issue(CMD_REMOVE, '0);
    issue(CMD_FIRST, '0);
    issue(CMD_REMOVE, '0);
    issue(CMD_REMOVE, '0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) issue(3'(c), -32'sd1);
    issue(CMD_CLEAR, -32'sd1);
    issue(CMD_FIRST, '0);
    drain();

    base = words_sent;
    random_phase(29, base + RANDOM_WORDS / 3);
    drain();
    random_phase(48, base + 2 * RANDOM_WORDS / 3);
    drain();
    random_phase(0, base + RANDOM_WORDS);
    drain();
    repeat (CAPACITY + 16) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("array_list_cursor_table_core verification clean");
    end else begin
      $display("array_list_cursor_table_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/alct_pkg.sv
src/alct_ram.sv
src/array_list_cursor_table_core.sv
dv/array_list_cursor_table_core_tb.sv
